// ===== rtl/mqff_pkg.sv =====
// shared types and codes for the multi-queue frame fifo
`timescale 1ns / 1ps

package mqff_pkg;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int QIDX_W   = 4;
   localparam int HANDLE_W = 16;
   localparam int COUNT_W  = 7;
   localparam int NUMQ_W   = 5;
   localparam int DEPTH_W  = 7;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // request operation codes; the unused code behaves as a query
   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ   = 2'd0,
      CMD_DEQ   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_SPARE = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // register index taken from the word address
   typedef enum logic {
      REG_NUM_QUEUES = 1'b0,
      REG_MAX_DEPTH  = 1'b1
   } reg_index_type;

   // control settings from the register block
   typedef struct packed {
      logic [NUMQ_W-1:0]  num_queues;
      logic [DEPTH_W-1:0] max_depth;
   } cfg_type;

   // store access for one request
   typedef struct packed {
      logic wr;
      logic rd;
   } store_cmd_type;

   // per-request response fields except the handle
   typedef struct packed {
      status_type         status;
      logic               deq_ok;
      logic [COUNT_W-1:0] count;
   } result_type;

endpackage

// ===== rtl/mqff_csr.sv =====
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module mqff_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mqff_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [mqff_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [mqff_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                csr_pready,
   output mqff_pkg::cfg_type                   cfg
);

   mqff_pkg::cfg_type       cfg_ff;
   mqff_pkg::cfg_type       cfg_in;
   mqff_pkg::reg_index_type sel;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign sel        = mqff_pkg::reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (sel)
            mqff_pkg::REG_NUM_QUEUES: cfg_in.num_queues = csr_pwdata[mqff_pkg::NUMQ_W-1:0];
            mqff_pkg::REG_MAX_DEPTH:  cfg_in.max_depth  = csr_pwdata[mqff_pkg::DEPTH_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_queues <= mqff_pkg::NUMQ_W'(16);
         cfg_ff.max_depth  <= mqff_pkg::DEPTH_W'(64);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read
   always_comb begin
      unique case (sel)
         mqff_pkg::REG_NUM_QUEUES: csr_prdata = mqff_pkg::CSR_DW'(cfg_ff.num_queues);
         mqff_pkg::REG_MAX_DEPTH:  csr_prdata = mqff_pkg::CSR_DW'(cfg_ff.max_depth);
         default:                  csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/mqff_ctrl.sv =====
// per-queue head, tail and count state with the request decode
`timescale 1ns / 1ps

module mqff_ctrl #(
   parameter int MAX_QUEUES  = 16,
   parameter int QUEUE_DEPTH = 64,
   parameter int QW          = 4,
   parameter int PW          = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  mqff_pkg::cmd_type                 cmd,
   input  logic [mqff_pkg::QIDX_W-1:0]       queue_index,
   input  mqff_pkg::cfg_type                 cfg,
   output mqff_pkg::store_cmd_type           store_cmd,
   output logic [QW+PW-1:0]                  store_addr,
   output mqff_pkg::result_type              result
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LW = (CW > mqff_pkg::DEPTH_W) ? CW : mqff_pkg::DEPTH_W;

   logic [PW-1:0] head_ff [MAX_QUEUES];
   logic [PW-1:0] tail_ff [MAX_QUEUES];
   logic [CW-1:0] count_ff [MAX_QUEUES];

   logic [QW-1:0] q_sel;
   logic          in_range;
   logic [PW-1:0] head_cur;
   logic [PW-1:0] tail_cur;
   logic [CW-1:0] count_cur;
   logic [LW-1:0] limit;
   logic          enq_ok;
   logic          deq_ok;
   logic [PW-1:0] head_in;
   logic [PW-1:0] tail_in;
   logic [CW-1:0] count_in;

   assign q_sel    = QW'(queue_index);
   assign in_range = ({1'b0, queue_index} < cfg.num_queues) &&
                     (32'(queue_index) < MAX_QUEUES);

   assign head_cur  = head_ff[q_sel];
   assign tail_cur  = tail_ff[q_sel];
   assign count_cur = count_ff[q_sel];

   // depth limit is the register value capped at the ring size
   assign limit = (LW'(cfg.max_depth) > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH)
                                                          : LW'(cfg.max_depth);

   assign enq_ok = in_range && (cmd == mqff_pkg::CMD_ENQ) && (LW'(count_cur) < limit);
   assign deq_ok = in_range && (cmd == mqff_pkg::CMD_DEQ) && (count_cur != '0);

   // ring pointer advance and count update
   always_comb begin
      head_in  = head_cur;
      tail_in  = tail_cur;
      count_in = count_cur;
      if (enq_ok) begin
         tail_in  = (tail_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_cur + 1'b1;
         count_in = count_cur + 1'b1;
      end else if (deq_ok) begin
         head_in  = (head_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
         count_in = count_cur - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_QUEUES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (fire && (enq_ok || deq_ok)) begin
         head_ff[q_sel]  <= head_in;
         tail_ff[q_sel]  <= tail_in;
         count_ff[q_sel] <= count_in;
      end
   end

   // store access
   assign store_cmd.wr = fire & enq_ok;
   assign store_cmd.rd = fire & deq_ok;
   assign store_addr   = {q_sel, (cmd == mqff_pkg::CMD_ENQ) ? tail_cur : head_cur};

   // response fields
   always_comb begin
      result.deq_ok = deq_ok;
      result.count  = in_range ? mqff_pkg::COUNT_W'(count_in) : '0;
      priority if (!in_range) begin
         result.status = mqff_pkg::ST_RANGE;
      end else if ((cmd == mqff_pkg::CMD_ENQ) && !enq_ok) begin
         result.status = mqff_pkg::ST_FULL;
      end else if ((cmd == mqff_pkg::CMD_DEQ) && !deq_ok) begin
         result.status = mqff_pkg::ST_EMPTY;
      end else begin
         result.status = mqff_pkg::ST_OK;
      end
   end

endmodule

// ===== rtl/mqff_store.sv =====
// shared handle store with one write port and a registered read port
`timescale 1ns / 1ps

module mqff_store #(
   parameter int ENTRIES = 1024,
   parameter int AW      = 10
) (
   input  logic                               clock,
   input  mqff_pkg::store_cmd_type            store_cmd,
   input  logic [AW-1:0]                      addr,
   input  logic [mqff_pkg::HANDLE_W-1:0]      wr_data,
   output logic [mqff_pkg::HANDLE_W-1:0]      rd_data
);

   logic [mqff_pkg::HANDLE_W-1:0] mem [ENTRIES];
   logic [mqff_pkg::HANDLE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (store_cmd.wr) begin
         mem[addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (store_cmd.rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/multi_queue_frame_fifo.sv =====
// top level of the multi-queue frame fifo
`timescale 1ns / 1ps
//
// Keeps MAX_QUEUES independent fifo queues of 16-bit frame handles, each a ring
// of QUEUE_DEPTH slots in one shared store, with its own head, tail and count.
// Request channel req_*: cmd (enqueue, dequeue, query), queue index and handle.
// Response channel rsp_*: status, dequeued handle (zero otherwise) and the
// queue's count after the request. One response per request, in order.
// Registers on csr_*: num_queues at byte address 0, max_depth at address 4.
// An accepted request waits in the request register; when the response
// register is free, decode, pointer update and store access complete into
// the response register and the store read register.
// Throughput is one request per cycle while rsp_tready is high; the handle
// store and per-queue pointer registers are touched at most once per request.
// When rsp_tready is low the response register holds and req_tready drops
// once the request register is also occupied; nothing is lost or repeated.
// Reset clears all queue pointers and counts and sets num_queues to 16 and
// max_depth to 64; the handle store itself is not cleared.
//
module multi_queue_frame_fifo #(
   parameter int MAX_QUEUES  = 16,
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request: [1:0] cmd, [5:2] queue_index, [21:6] frame_handle
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // response: [1:0] status, [17:2] out_handle, [24:18] queue_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int QW      = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
   localparam int PW      = $clog2(QUEUE_DEPTH);
   localparam int AW      = QW + PW;
   localparam int ENTRIES = MAX_QUEUES * (2 ** PW);

   mqff_pkg::cfg_type                  cfg;
   mqff_pkg::store_cmd_type            store_cmd;
   logic [AW-1:0]                      store_addr;
   mqff_pkg::result_type               result;
   logic [mqff_pkg::HANDLE_W-1:0]      rd_data;

   logic                               s1_valid_ff;
   logic                               s1_valid_in;
   mqff_pkg::cmd_type                  s1_cmd_ff;
   logic [mqff_pkg::QIDX_W-1:0]        s1_q_ff;
   logic [mqff_pkg::HANDLE_W-1:0]      s1_handle_ff;
   logic                               s2_valid_ff;
   logic                               s2_valid_in;
   mqff_pkg::result_type               s2_result_ff;

   logic                               req_fire;
   logic                               s2_free;
   logic                               advance;
   logic [mqff_pkg::HANDLE_W-1:0]      out_handle;

   mqff_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // pipeline handshake
   assign s2_free    = !s2_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s2_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (advance) begin
         s2_valid_in = 1'b1;
      end else if (rsp_tready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff    <= mqff_pkg::cmd_type'(req_tdata[1:0]);
         s1_q_ff      <= req_tdata[5:2];
         s1_handle_ff <= req_tdata[21:6];
      end
   end

   mqff_ctrl #(
      .MAX_QUEUES  (MAX_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .QW          (QW),
      .PW          (PW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .cmd         (s1_cmd_ff),
      .queue_index (s1_q_ff),
      .cfg         (cfg),
      .store_cmd   (store_cmd),
      .store_addr  (store_addr),
      .result      (result)
   );

   mqff_store #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_store (
      .clock     (clock),
      .store_cmd (store_cmd),
      .addr      (store_addr),
      .wr_data   (s1_handle_ff),
      .rd_data   (rd_data)
   );

   // response register, aligned with the store read register
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_result_ff <= result;
      end
   end

   assign out_handle = s2_result_ff.deq_ok ? rd_data : '0;
   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {7'b0, s2_result_ff.count, out_handle, s2_result_ff.status};

endmodule

// ===== sim/mqff_response_checker.sv =====
// response checker for the multi-queue frame fifo: predicts and compares every response
`timescale 1ns / 1ps

module mqff_response_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_count
);

   localparam int QUEUES      = 16;
   localparam int DEPTH       = 64;
   localparam int PTR_W       = 6;

   typedef struct {
      mqff_pkg::status_type          status;
      logic [mqff_pkg::HANDLE_W-1:0] handle;
      logic [mqff_pkg::COUNT_W-1:0]  count;
   } response_type;

   // predicted queue state, mirrors the block's rings
   response_type                  predicted_responses[$];
   logic [mqff_pkg::HANDLE_W-1:0] handle_ring[QUEUES*DEPTH];
   logic [PTR_W-1:0]              head_ptr[QUEUES];
   logic [PTR_W-1:0]              tail_ptr[QUEUES];
   logic [mqff_pkg::COUNT_W-1:0]  fill_level[QUEUES];
   logic [mqff_pkg::NUMQ_W-1:0]   queues_in_use;
   logic [mqff_pkg::DEPTH_W-1:0]  depth_setting;

   // work out the response of one request and update the predicted queues
   task automatic predict_response(input mqff_pkg::cmd_type op,
                                   input logic [mqff_pkg::QIDX_W-1:0] q,
                                   input logic [mqff_pkg::HANDLE_W-1:0] h,
                                   output response_type r);
      logic [mqff_pkg::DEPTH_W-1:0] limit;
      r.status = mqff_pkg::ST_OK;
      r.handle = '0;
      r.count  = '0;
      if ({1'b0, q} >= queues_in_use) begin
         r.status = mqff_pkg::ST_RANGE;
      end else begin
         // depth limit is capped at the ring size
         limit = (depth_setting > mqff_pkg::DEPTH_W'(DEPTH)) ? mqff_pkg::DEPTH_W'(DEPTH)
                                                             : depth_setting;
         case (op)
            mqff_pkg::CMD_ENQ: begin
               if (fill_level[q] >= limit) begin
                  r.status = mqff_pkg::ST_FULL;
               end else begin
                  handle_ring[{q, tail_ptr[q]}] = h;
                  tail_ptr[q]   = tail_ptr[q] + 1'b1;
                  fill_level[q] = fill_level[q] + 1'b1;
               end
            end
            mqff_pkg::CMD_DEQ: begin
               if (fill_level[q] == '0) begin
                  r.status = mqff_pkg::ST_EMPTY;
               end else begin
                  r.handle      = handle_ring[{q, head_ptr[q]}];
                  head_ptr[q]   = head_ptr[q] + 1'b1;
                  fill_level[q] = fill_level[q] - 1'b1;
               end
            end
            default: ;
         endcase
         r.count = fill_level[q];
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      fail_count++;
      $error("%s: expected %0d, actual %0d", field, want, got);
   endtask

   always @(posedge clock) begin : watch
      response_type want;
      response_type got;
      if (reset) begin
         predicted_responses.delete();
         for (int i = 0; i < QUEUES; i++) begin
            head_ptr[i]   = '0;
            tail_ptr[i]   = '0;
            fill_level[i] = '0;
         end
         queues_in_use = mqff_pkg::NUMQ_W'(16);
         depth_setting = mqff_pkg::DEPTH_W'(64);
         fail_count    = 0;
         pending_count = 0;
      end else begin
         // responses first, so the oldest prediction is matched
         if (rsp_tvalid && rsp_tready) begin
            got.status = mqff_pkg::status_type'(rsp_tdata[1:0]);
            got.handle = rsp_tdata[17:2];
            got.count  = rsp_tdata[24:18];
            if (predicted_responses.size() == 0) begin
               fail_count++;
               $error("response with no request pending: tdata %h", rsp_tdata);
            end else begin
               want = predicted_responses.pop_front();
               if (got.status !== want.status) begin
                  report_mismatch("status", 32'(want.status), 32'(got.status));
               end
               if (got.handle !== want.handle) begin
                  report_mismatch("out_handle", 32'(want.handle), 32'(got.handle));
               end
               if (got.count !== want.count) begin
                  report_mismatch("queue_count", 32'(want.count), 32'(got.count));
               end
            end
         end
         // accepted request
         if (req_tvalid && req_tready) begin
            predict_response(mqff_pkg::cmd_type'(req_tdata[1:0]), req_tdata[5:2],
                             req_tdata[21:6], want);
            predicted_responses.push_back(want);
         end
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (mqff_pkg::reg_index_type'(csr_paddr[2]))
               mqff_pkg::REG_NUM_QUEUES: queues_in_use = csr_pwdata[mqff_pkg::NUMQ_W-1:0];
               mqff_pkg::REG_MAX_DEPTH:  depth_setting = csr_pwdata[mqff_pkg::DEPTH_W-1:0];
               default: ;
            endcase
         end
         pending_count = predicted_responses.size();
      end
   end

endmodule

// ===== sim/tb_multi_queue_frame_fifo.sv =====
// testbench top for the multi-queue frame fifo: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_multi_queue_frame_fifo;

   localparam int TOTAL_ITEMS = 1100;
   localparam int QUIET_LIMIT = 4000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // request: [1:0] cmd, [5:2] queue_index, [21:6] frame_handle
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // response: [1:0] status, [17:2] out_handle, [24:18] queue_count
   logic [31:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending_count;
   int items_sent;
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;

   multi_queue_frame_fifo dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mqff_response_checker response_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // response backpressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
                   || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("multi_queue_frame_fifo: mismatch");
            $finish;
         end
      end
   end

   // one request; entered and left at a falling edge
   task automatic send_request(input mqff_pkg::cmd_type op,
                               input logic [mqff_pkg::QIDX_W-1:0] q,
                               input logic [mqff_pkg::HANDLE_W-1:0] h);
      // idle pattern moves through three stages over the run
      if (items_sent < TOTAL_ITEMS / 3) begin
         send_idle_pct  = 6;
         recv_stall_pct = 50;
      end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
         send_idle_pct  = 50;
         recv_stall_pct = 6;
      end else begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, h, q, op};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic write_register(input mqff_pkg::reg_index_type idx, input logic [6:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      // junk above the field must be ignored
      csr_pwdata  <= ($urandom & ~32'h7F) | {25'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // change settings only with nothing in flight
   task automatic apply_settings(input logic [6:0] nq, input logic [6:0] md);
      wait_until_drained();
      write_register(mqff_pkg::REG_NUM_QUEUES, nq);
      write_register(mqff_pkg::REG_MAX_DEPTH, md);
   endtask

   // bursts on one queue: fill runs, drain runs and mixed runs, plus noise over random queues
   task automatic run_random(input int n);
      int left;
      int len;
      int style;
      logic [mqff_pkg::QIDX_W-1:0]   q;
      logic [mqff_pkg::HANDLE_W-1:0] h;
      mqff_pkg::cmd_type             op;
      left = n;
      while (left > 0) begin
         q     = mqff_pkg::QIDX_W'($urandom_range(15));
         style = $urandom_range(9);
         len   = ($urandom_range(3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 12);
         if (len > left) len = left;
         repeat (len) begin
            h = mqff_pkg::HANDLE_W'($urandom);
            case ($urandom_range(7))
               0: h = '0;
               1: h = '1;
               default: ;
            endcase
            if (style < 4) begin
               op = ($urandom_range(9) < 8) ? mqff_pkg::CMD_ENQ
                                            : mqff_pkg::cmd_type'($urandom_range(3));
            end else if (style < 7) begin
               op = ($urandom_range(9) < 8) ? mqff_pkg::CMD_DEQ
                                            : mqff_pkg::cmd_type'($urandom_range(3));
            end else begin
               op = mqff_pkg::cmd_type'($urandom_range(3));
               if (style == 9) q = mqff_pkg::QIDX_W'($urandom_range(15));
            end
            send_request(op, q, h);
         end
         left -= len;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      items_sent     = 0;
      send_idle_pct  = 6;
      recv_stall_pct = 50;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, empty and single-entry cases, handle extremes
      send_request(mqff_pkg::CMD_QUERY, 4'd0, 16'h1234);
      send_request(mqff_pkg::CMD_DEQ,   4'd0, 16'hFFFF);
      send_request(mqff_pkg::CMD_ENQ,   4'd0, 16'hFFFF);
      send_request(mqff_pkg::CMD_ENQ,   4'd0, 16'h0000);
      send_request(mqff_pkg::CMD_ENQ,   4'd15, 16'hA5A5);
      send_request(mqff_pkg::CMD_SPARE, 4'd15, 16'hFFFF);
      send_request(mqff_pkg::CMD_DEQ,   4'd0, 16'h0000);
      send_request(mqff_pkg::CMD_DEQ,   4'd0, 16'h5A5A);
      send_request(mqff_pkg::CMD_DEQ,   4'd0, 16'h0000);
      send_request(mqff_pkg::CMD_DEQ,   4'd15, 16'h0000);
      send_request(mqff_pkg::CMD_ENQ,   4'd7, 16'h5A5A);
      send_request(mqff_pkg::CMD_QUERY, 4'd7, 16'h0000);
      run_random(150);

      // few queues, shallow limit; upper queues keep their contents
      apply_settings(7'd4, 7'd5);
      send_request(mqff_pkg::CMD_ENQ, 4'd4, 16'hBEEF);
      send_request(mqff_pkg::CMD_DEQ, 4'd3, 16'h0000);
      run_random(200);

      // all indices in range, depth above the ring size is capped
      apply_settings(7'd31, 7'd127);
      run_random(200);

      // no queue in use, zero depth
      apply_settings(7'd0, 7'd0);
      send_request(mqff_pkg::CMD_ENQ,   4'd0, 16'h0001);
      send_request(mqff_pkg::CMD_DEQ,   4'd0, 16'h0000);
      send_request(mqff_pkg::CMD_QUERY, 4'd15, 16'h0000);
      run_random(20);

      // one queue of depth one
      apply_settings(7'd1, 7'd1);
      send_request(mqff_pkg::CMD_DEQ, 4'd0, 16'h0000);
      send_request(mqff_pkg::CMD_ENQ, 4'd0, 16'hC3C3);
      send_request(mqff_pkg::CMD_ENQ, 4'd0, 16'h3C3C);
      send_request(mqff_pkg::CMD_DEQ, 4'd1, 16'h0000);
      send_request(mqff_pkg::CMD_DEQ, 4'd0, 16'h0000);
      run_random(100);

      // zero depth with every queue open: enqueues fail, dequeues drain
      apply_settings(7'd16, 7'd0);
      run_random(60);

      // limit lowered below what queues already hold
      apply_settings(7'd9, 7'd3);
      run_random(150);

      // back to full size, hidden contents reachable again
      apply_settings(7'd16, 7'd64);
      run_random(220);

      // drain and settle
      wait_until_drained();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("multi_queue_frame_fifo: match");
      end else begin
         $display("multi_queue_frame_fifo: mismatch");
      end
      $finish;
   end

endmodule
